@@ src/pshp_pkg.sv @@
// Package: shared types, constants and phase codes for the stream header parser.
`default_nettype none
package pshp_pkg;
   localparam logic [7:0] CODE_PACK   = 8'hBA;
   localparam logic [7:0] CODE_SYS    = 8'hBB;
   localparam logic [7:0] CODE_MAP    = 8'hBC;
   localparam logic [7:0] PES_RESET   = 8'd189;
   localparam logic [23:0] PREFIX     = 24'h000001;

   localparam logic [1:0] KIND_PACK  = 2'd0;
   localparam logic [1:0] KIND_SYS   = 2'd1;
   localparam logic [1:0] KIND_ENTRY = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   typedef enum logic [8:0] {
      PH_HUNT      = 9'b000000001,
      PH_PACK      = 9'b000000010,
      PH_STUFF     = 9'b000000100,
      PH_SYS_LEN   = 9'b000001000,
      PH_SYS_FIXED = 9'b000010000,
      PH_ENTRY     = 9'b000100000,
      PH_SKIP      = 9'b001000000,
      PH_LEN       = 9'b010000000,
      PH_BODY      = 9'b100000000
   } phase_type;

   // Handling a byte gets if it turns out to be the code after a prefix.
   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_PACK = 2'd1,
      CLS_SYS  = 2'd2,
      CLS_LEN  = 2'd3
   } code_class_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  code_value;
      logic [32:0] clock_base;
      logic [8:0]  clock_ext;
      logic [21:0] rate_value;
      logic [5:0]  audio_limit;
      logic [4:0]  video_limit;
      logic [3:0]  header_flags;
      logic [7:0]  entry_stream;
      logic        entry_scale;
      logic [12:0] entry_size_bound;
   } result_type;

   // Classified byte handed from front to back.
   typedef struct packed {
      code_class_type cls;
      logic [7:0]     data;
   } token_type;
endpackage
`default_nettype wire

@@ src/pshp_if.sv @@
// Interfaces: byte request channel and result channel.
`default_nettype none
interface pshp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface pshp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0]  kind;
   logic [7:0]  code_value;
   logic [32:0] clock_base;
   logic [8:0]  clock_ext;
   logic [21:0] rate_value;
   logic [5:0]  audio_limit;
   logic [4:0]  video_limit;
   logic [3:0]  header_flags;
   logic [7:0]  entry_stream;
   logic        entry_scale;
   logic [12:0] entry_size_bound;
   modport source (output valid, output kind, output code_value, output clock_base,
      output clock_ext, output rate_value, output audio_limit, output video_limit,
      output header_flags, output entry_stream, output entry_scale,
      output entry_size_bound, input ready);
   modport sink (input valid, input kind, input code_value, input clock_base,
      input clock_ext, input rate_value, input audio_limit, input video_limit,
      input header_flags, input entry_stream, input entry_scale,
      input entry_size_bound, output ready);
endinterface
`default_nettype wire

@@ src/pshp_queue.sv @@
// Short FIFO of classified bytes between front and back.
`default_nettype none
module pshp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pshp_pkg::token_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output pshp_pkg::token_type       pop_data,
   output logic                      not_empty
);
   pshp_pkg::token_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

@@ src/pshp_front.sv @@
// Front: accepts bytes and decodes how each would be handled as a start code.
`default_nettype none
module pshp_front (
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_byte,
   input  wire logic [7:0]           pes_id_start,
   input  wire logic                 q_full,
   output logic                      push,
   output pshp_pkg::token_type       push_data
);
   // The back owns the prefix search, since only it knows where hunting
   // resumes; the front decodes the code class so the back only selects.
   pshp_pkg::code_class_type cls;

   assign in_ready  = !q_full;
   assign push      = in_valid && in_ready;
   assign push_data = '{cls: cls, data: in_byte};

   // decode the code class of the byte
   always_comb begin
      if (in_byte == pshp_pkg::CODE_PACK) cls = pshp_pkg::CLS_PACK;
      else if (in_byte == pshp_pkg::CODE_SYS) cls = pshp_pkg::CLS_SYS;
      else if (in_byte == pshp_pkg::CODE_MAP || in_byte >= pes_id_start)
         cls = pshp_pkg::CLS_LEN;
      else cls = pshp_pkg::CLS_NONE;
   end
endmodule
`default_nettype wire

@@ src/pshp_back.sv @@
// Back: runs the header phases on queued bytes and drives the result register.
`default_nettype none
module pshp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_valid,
   input  wire pshp_pkg::token_type  tok,
   output logic                      tok_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pshp_pkg::result_type      rsp_data
);
   pshp_pkg::phase_type phase_ff, phase_in;
   logic [23:0] recent_ff, recent_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] rem_ff, rem_in;
   logic [2:0]  stuff_ff, stuff_in;
   logic [79:0] bits_ff, bits_in;
   logic [7:0]  code_ff, code_in;
   logic        out_v_ff, out_v_in;
   pshp_pkg::result_type out_ff, out_in, res;
   logic        emit;
   logic        resync;
   logic [7:0]  b;
   logic [79:0] pk;
   logic [47:0] sv;
   logic [23:0] ev;
   logic [15:0] rem_dec;

   assign b       = tok.data;
   // take a byte when the result slot is free or being drained
   assign tok_pop = tok_valid && (!out_v_ff || rsp_ready);
   assign rem_dec = rem_ff - 16'd1;

   // next-state and result
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; rem_in = rem_ff; stuff_in = stuff_ff;
      bits_in = bits_ff; code_in = code_ff; emit = 1'b0; res = '0; resync = 1'b0;
      recent_in = recent_ff;
      pk = bits_ff; sv = bits_ff[47:0]; ev = bits_ff[23:0];
      if (tok_pop) begin
         case (phase_ff)
            pshp_pkg::PH_PACK: begin
               pk = {bits_ff[71:0], b};
               bits_in = pk;
               pos_in = pos_ff + 16'd1;
               if (pos_ff == 16'd9) begin
                  stuff_in = pk[2:0];
                  if (pk[2:0] == 3'd0) emit = 1'b1;
                  else phase_in = pshp_pkg::PH_STUFF;
               end
            end
            pshp_pkg::PH_STUFF: begin
               stuff_in = stuff_ff - 3'd1;
               if (stuff_ff == 3'd1) emit = 1'b1;
            end
            pshp_pkg::PH_SYS_LEN, pshp_pkg::PH_LEN: begin
               if (pos_ff == 16'd0) begin
                  rem_in = {b, 8'h00};
                  pos_in = 16'd1;
               end else begin
                  rem_in = rem_ff | {8'h00, b};
                  pos_in = '0;
                  bits_in = '0;
                  if (phase_ff == pshp_pkg::PH_SYS_LEN) phase_in = pshp_pkg::PH_SYS_FIXED;
                  else if ((rem_ff | {8'h00, b}) == 16'd0) begin
                     res.kind = pshp_pkg::KIND_OTHER; res.code_value = code_ff;
                     emit = 1'b1;
                  end else phase_in = pshp_pkg::PH_BODY;
               end
            end
            pshp_pkg::PH_SYS_FIXED: begin
               sv = {bits_ff[39:0], b};
               bits_in = {32'h0, sv};
               pos_in = pos_ff + 16'd1;
               if (pos_ff == 16'd5) begin
                  res.kind = pshp_pkg::KIND_SYS; res.code_value = code_ff;
                  res.rate_value = sv[46:25]; res.audio_limit = sv[23:18];
                  res.video_limit = sv[12:8]; res.header_flags = sv[17:14];
                  emit = 1'b1;
                  rem_in = (rem_ff >= 16'd6) ? rem_ff - 16'd6 : 16'd0;
                  if (rem_ff > 16'd6) begin
                     phase_in = pshp_pkg::PH_ENTRY; pos_in = '0; bits_in = '0;
                  end
               end
            end
            pshp_pkg::PH_ENTRY: begin
               rem_in = rem_dec;
               if (pos_ff == 16'd0 && (rem_ff < 16'd3 || !b[7])) begin
                  phase_in = pshp_pkg::PH_SKIP;
                  if (rem_dec == 16'd0) begin
                     phase_in = pshp_pkg::PH_HUNT; resync = 1'b1;
                  end
               end else begin
                  ev = {bits_ff[15:0], b};
                  bits_in = {56'h0, ev};
                  pos_in = pos_ff + 16'd1;
                  if (pos_ff == 16'd2) begin
                     res.kind = pshp_pkg::KIND_ENTRY; res.code_value = code_ff;
                     res.entry_stream = ev[23:16]; res.entry_scale = ev[13];
                     res.entry_size_bound = ev[12:0];
                     emit = 1'b1; pos_in = '0;
                     if (rem_dec == 16'd0) begin
                        phase_in = pshp_pkg::PH_HUNT; resync = 1'b1;
                     end
                  end else if (rem_dec == 16'd0) begin
                     // header length ran out inside an entry; keep model behavior
                     rem_in = rem_dec;
                  end
               end
            end
            pshp_pkg::PH_SKIP, pshp_pkg::PH_BODY: begin
               if (rem_ff != 16'd0) rem_in = rem_dec;
               if (rem_ff <= 16'd1) begin
                  if (phase_ff == pshp_pkg::PH_BODY) begin
                     res.kind = pshp_pkg::KIND_OTHER; res.code_value = code_ff;
                     emit = 1'b1;
                  end else begin
                     phase_in = pshp_pkg::PH_HUNT; resync = 1'b1;
                  end
               end
            end
            default: begin
               // hunt for the prefix; the code byte after it picks the phase
               if (pos_ff >= 16'd3 && recent_ff == pshp_pkg::PREFIX) begin
                  code_in = b; pos_in = '0; bits_in = '0; recent_in = '0;
                  case (tok.cls)
                     pshp_pkg::CLS_PACK: phase_in = pshp_pkg::PH_PACK;
                     pshp_pkg::CLS_SYS:  phase_in = pshp_pkg::PH_SYS_LEN;
                     pshp_pkg::CLS_LEN:  phase_in = pshp_pkg::PH_LEN;
                     default:            phase_in = pshp_pkg::PH_HUNT;
                  endcase
               end else begin
                  recent_in = {recent_ff[15:0], b};
                  pos_in = (pos_ff >= 16'd3) ? 16'd3 : pos_ff + 16'd1;
               end
            end
         endcase
         // back to hunting on emit unless entries follow; fill pack results
         if (emit && phase_ff != pshp_pkg::PH_ENTRY && phase_ff != pshp_pkg::PH_SYS_FIXED) begin
            phase_in = pshp_pkg::PH_HUNT; resync = 1'b1;
         end
         if (emit && phase_ff == pshp_pkg::PH_SYS_FIXED && rem_ff <= 16'd6) begin
            phase_in = pshp_pkg::PH_HUNT; resync = 1'b1;
         end
         if (emit && (phase_ff == pshp_pkg::PH_PACK || phase_ff == pshp_pkg::PH_STUFF)) begin
            res.kind = pshp_pkg::KIND_PACK; res.code_value = code_ff;
            res.clock_base = {pk[77:75], pk[73:59], pk[57:43]};
            res.clock_ext  = pk[41:33];
            res.rate_value = pk[31:10];
         end
         // restart the prefix search from scratch
         if (resync) begin
            pos_in = '0; recent_in = '0;
         end
      end
   end

   // hold the result until taken
   always_comb begin
      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (rsp_ready) out_v_in = 1'b0;
      if (emit) begin
         out_v_in = 1'b1;
         out_in   = res;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pshp_pkg::PH_HUNT; recent_ff <= '0;
         pos_ff <= '0; rem_ff <= '0; stuff_ff <= '0; bits_ff <= '0; code_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; recent_ff <= recent_in;
         pos_ff <= pos_in; rem_ff <= rem_in; stuff_ff <= stuff_in;
         bits_ff <= bits_in; code_ff <= code_in;
         out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff)) else $error("phase not one-hot");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      emit |-> !out_v_ff || rsp_ready) else $error("result overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_ready |=> out_v_ff && $stable(out_ff)) else $error("result lost");
`endif
endmodule
`default_nettype wire

@@ src/program_stream_header_parser_core.sv @@
// Timing: the byte that completes a result passes through the queue; the back then
// registers the result, which the output register holds until rsp.ready takes it.
// Throughput: one byte per cycle; input stalls only once the two-entry queue fills
// behind a result held for rsp.ready. A one-entry output register holds results.
// Reset (synchronous, active high) returns to hunting and sets pes_id_start to 189.
// Top level: program stream header parser.
`default_nettype none
module program_stream_header_parser_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data,
   pshp_req_if.sink        req,
   pshp_rsp_if.source      rsp
);
   logic [7:0] pes_ff, pes_in;
   logic q_full, q_push, q_pop, q_ne;
   pshp_pkg::token_type q_in, q_out;
   pshp_pkg::result_type res;

   // configuration register
   always_comb pes_in = csr_write_enable ? csr_write_data : pes_ff;
   always_ff @(posedge clock) begin
      if (reset) pes_ff <= pshp_pkg::PES_RESET;
      else pes_ff <= pes_in;
   end

   pshp_front u_front (.in_valid(req.valid), .in_ready(req.ready),
      .in_byte(req.data_byte), .pes_id_start(pes_ff), .q_full(q_full),
      .push(q_push), .push_data(q_in));

   pshp_queue u_queue (.clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .pop_data(q_out), .not_empty(q_ne));

   pshp_back u_back (.clock(clock), .reset(reset),
      .tok_valid(q_ne), .tok(q_out), .tok_pop(q_pop),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(res));

   assign rsp.kind = res.kind;
   assign rsp.code_value = res.code_value;
   assign rsp.clock_base = res.clock_base;
   assign rsp.clock_ext = res.clock_ext;
   assign rsp.rate_value = res.rate_value;
   assign rsp.audio_limit = res.audio_limit;
   assign rsp.video_limit = res.video_limit;
   assign rsp.header_flags = res.header_flags;
   assign rsp.entry_stream = res.entry_stream;
   assign rsp.entry_scale = res.entry_scale;
   assign rsp.entry_size_bound = res.entry_size_bound;
endmodule
`default_nettype wire
